[src/icrc_pkg.sv]
// shared types and constants of the isosurface cube row classifier
package icrc_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CASE_W = 8;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned NUM_COUNTS = 8;
  localparam int unsigned NUM_SAMPLES = 4;

  // largest grid row length in x
  localparam int unsigned NX_MAX = 1024;
  // largest value an 11-bit count field can hold
  localparam int unsigned CNT_FIELD_MAX = (1 << CNT_W) - 1;
  // saturation level of every cut count
  localparam int unsigned CNT_CAP = (NX_MAX < CNT_FIELD_MAX) ? NX_MAX : CNT_FIELD_MAX;

  // positions of the eight counts
  localparam int unsigned CNT_A_X = 0;
  localparam int unsigned CNT_A_Y = 1;
  localparam int unsigned CNT_A_Z = 2;
  localparam int unsigned CNT_B_X = 3;
  localparam int unsigned CNT_B_Z = 4;
  localparam int unsigned CNT_C_X = 5;
  localparam int unsigned CNT_C_Y = 6;
  localparam int unsigned CNT_D_X = 7;

  typedef logic [NUM_COUNTS-1:0][CNT_W-1:0] cnt_vec_t;

  // boundary flags carried with one transaction
  typedef struct packed {
    logic y_end;
    logic z_end;
    logic x_end;
  } row_flags_t;

endpackage

[src/icrc_cut_counter.sv]
// saturating cut-edge counters for the four grid rows of one cube row
module icrc_cut_counter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         upd_i,
  input  logic [icrc_pkg::CASE_W-1:0]  cube_i,
  input  icrc_pkg::row_flags_t         flags_i,
  output icrc_pkg::cnt_vec_t           cnt_next_o
);

  localparam logic [icrc_pkg::CNT_W:0] CapWide = (icrc_pkg::CNT_W + 1)'(icrc_pkg::CNT_CAP);

  icrc_pkg::cnt_vec_t cnt_q, cnt_d;
  logic [icrc_pkg::NUM_COUNTS-1:0][1:0] inc;

  // edge between two cube vertices is cut when their inside bits differ
  function automatic logic [1:0] cut(input logic [icrc_pkg::CASE_W-1:0] cube,
                                     input int unsigned p, input int unsigned q);
    return {1'b0, cube[p] ^ cube[q]};
  endfunction

  // per-count increments, boundary edges only at the matching ends
  always_comb begin
    inc = '0;
    inc[icrc_pkg::CNT_A_X] = cut(cube_i, 0, 1);
    inc[icrc_pkg::CNT_A_Y] = cut(cube_i, 0, 3) + (flags_i.x_end ? cut(cube_i, 1, 2) : 2'd0);
    inc[icrc_pkg::CNT_A_Z] = cut(cube_i, 0, 4) + (flags_i.x_end ? cut(cube_i, 1, 5) : 2'd0);
    if (flags_i.y_end) begin
      inc[icrc_pkg::CNT_B_X] = cut(cube_i, 2, 3);
      inc[icrc_pkg::CNT_B_Z] = cut(cube_i, 3, 7) + (flags_i.x_end ? cut(cube_i, 2, 6) : 2'd0);
    end
    if (flags_i.z_end) begin
      inc[icrc_pkg::CNT_C_X] = cut(cube_i, 4, 5);
      inc[icrc_pkg::CNT_C_Y] = cut(cube_i, 4, 7) + (flags_i.x_end ? cut(cube_i, 5, 6) : 2'd0);
    end
    if (flags_i.y_end && flags_i.z_end) begin
      inc[icrc_pkg::CNT_D_X] = cut(cube_i, 6, 7);
    end
  end

  // saturating add per count
  always_comb begin
    logic [icrc_pkg::CNT_W:0] sum;
    sum = '0;
    for (int n = 0; n < icrc_pkg::NUM_COUNTS; n++) begin
      sum = {1'b0, cnt_q[n]} + {{(icrc_pkg::CNT_W - 1){1'b0}}, inc[n]};
      cnt_next_o[n] = (sum > CapWide) ? CapWide[icrc_pkg::CNT_W-1:0]
                                      : sum[icrc_pkg::CNT_W-1:0];
    end
  end

  // counts restart after the cube that closes the row
  always_comb begin
    cnt_d = cnt_q;
    if (upd_i) begin
      cnt_d = flags_i.x_end ? '0 : cnt_next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

[src/isosurface_cube_row_classifier.sv]
// top level of the isosurface cube row classifier
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one grid column per
//   transaction: the four samples at position i of rows (j,k), (j+1,k),
//   (j,k+1), (j+1,k+1) plus the y, z and x end flags.
//   Output channel (out_valid_o / out_ready_i) gives one transaction per
//   closed cube: the 8-bit vertex case, eight running cut counts and
//   row_done on the cube ending at the last grid point of the row.
//   The first column of a row closes no cube and gives no output.
//   cfg_we_i / cfg_wdata_i write iso_level; write only while idle.
// Timing:
//   One input register (inside bits and flags) and one result register;
//   out_valid_o rises once the closing column has passed through the
//   input register and been captured in the result register.
//   One transaction per cycle in each direction unless the receiver stalls;
//   the inside compare sits before the input register, case and counts between the two.
// Reset and stall:
//   Reset clears iso_level, the held column and the running counts; the result registers are not reset.
//   While the receiver stalls with a result held, both stages hold and
//   in_ready_o falls once the input register is occupied.
module isosurface_cube_row_classifier (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic signed [icrc_pkg::SAMPLE_W-1:0] cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [icrc_pkg::SAMPLE_W-1:0] sample_a_i,
  input  logic signed [icrc_pkg::SAMPLE_W-1:0] sample_b_i,
  input  logic signed [icrc_pkg::SAMPLE_W-1:0] sample_c_i,
  input  logic signed [icrc_pkg::SAMPLE_W-1:0] sample_d_i,
  input  logic                                y_end_i,
  input  logic                                z_end_i,
  input  logic                                last_in_row_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [icrc_pkg::CASE_W-1:0]         cube_case_o,
  output logic [icrc_pkg::CNT_W-1:0]          row_a_x_cuts_o,
  output logic [icrc_pkg::CNT_W-1:0]          row_a_y_cuts_o,
  output logic [icrc_pkg::CNT_W-1:0]          row_a_z_cuts_o,
  output logic [icrc_pkg::CNT_W-1:0]          row_b_x_cuts_o,
  output logic [icrc_pkg::CNT_W-1:0]          row_b_z_cuts_o,
  output logic [icrc_pkg::CNT_W-1:0]          row_c_x_cuts_o,
  output logic [icrc_pkg::CNT_W-1:0]          row_c_y_cuts_o,
  output logic [icrc_pkg::CNT_W-1:0]          row_d_x_cuts_o,
  output logic                                row_done_o
);

  localparam logic [icrc_pkg::CNT_W-1:0] Cap = icrc_pkg::CNT_W'(icrc_pkg::CNT_CAP);

  logic signed [icrc_pkg::SAMPLE_W-1:0] iso_q;

  // input register stage
  logic                                    s1_valid_q;
  logic [icrc_pkg::NUM_SAMPLES-1:0]        s1_inside_q, s1_inside_d;
  icrc_pkg::row_flags_t                    s1_flags_q;
  logic                                    s1_adv, in_fire;

  // row state
  logic                                    have_prev_q, have_prev_d;
  logic [icrc_pkg::NUM_SAMPLES-1:0]        prev_inside_q, prev_inside_d;

  // result register stage
  logic                                    out_valid_q, out_valid_d;
  logic [icrc_pkg::CASE_W-1:0]             case_q, cube;
  icrc_pkg::cnt_vec_t                      cnt_q, cnt_next;
  logic                                    done_q;
  logic                                    res_fire;

  // handshake: stage 1 moves on when the result register is free or drains
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign res_fire   = s1_valid_q && s1_adv && have_prev_q;

  // inside test against the iso level
  assign s1_inside_d = {sample_d_i >= iso_q, sample_c_i >= iso_q,
                        sample_b_i >= iso_q, sample_a_i >= iso_q};

  // cube vertex case from the held and the current column
  assign cube = {prev_inside_q[3], s1_inside_q[3], s1_inside_q[2], prev_inside_q[2],
                 prev_inside_q[1], s1_inside_q[1], s1_inside_q[0], prev_inside_q[0]};

  icrc_cut_counter u_cut_counter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (res_fire),
    .cube_i     (cube),
    .flags_i    (s1_flags_q),
    .cnt_next_o (cnt_next)
  );

  // row state update on each transaction leaving stage 1
  always_comb begin
    have_prev_d   = have_prev_q;
    prev_inside_d = prev_inside_q;
    if (s1_valid_q && s1_adv) begin
      if (s1_flags_q.x_end) begin
        have_prev_d   = 1'b0;
        prev_inside_d = '0;
      end else begin
        have_prev_d   = 1'b1;
        prev_inside_d = s1_inside_q;
      end
    end
  end

  assign out_valid_d = res_fire || (out_valid_q && !out_ready_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iso_q         <= '0;
      s1_valid_q    <= 1'b0;
      have_prev_q   <= 1'b0;
      prev_inside_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        iso_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      have_prev_q   <= have_prev_d;
      prev_inside_q <= prev_inside_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_inside_q <= s1_inside_d;
      s1_flags_q  <= '{y_end: y_end_i, z_end: z_end_i, x_end: last_in_row_i};
    end
    if (res_fire) begin
      case_q <= cube;
      cnt_q  <= cnt_next;
      done_q <= s1_flags_q.x_end;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cube_case_o    = case_q;
  assign row_a_x_cuts_o = cnt_q[icrc_pkg::CNT_A_X];
  assign row_a_y_cuts_o = cnt_q[icrc_pkg::CNT_A_Y];
  assign row_a_z_cuts_o = cnt_q[icrc_pkg::CNT_A_Z];
  assign row_b_x_cuts_o = cnt_q[icrc_pkg::CNT_B_X];
  assign row_b_z_cuts_o = cnt_q[icrc_pkg::CNT_B_Z];
  assign row_c_x_cuts_o = cnt_q[icrc_pkg::CNT_C_X];
  assign row_c_y_cuts_o = cnt_q[icrc_pkg::CNT_C_Y];
  assign row_d_x_cuts_o = cnt_q[icrc_pkg::CNT_D_X];
  assign row_done_o     = done_q;

  // a cube closing the row leaves no held column behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire && s1_flags_q.x_end |=> !have_prev_q)
    else $error("held column survives end of row");

  // a column held in stage 1 is kept while the result register is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_inside_q) && $stable(s1_flags_q))
    else $error("stage 1 column lost during stall");

  // counts never pass the saturation level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> cnt_q[0] <= Cap && cnt_q[1] <= Cap && cnt_q[2] <= Cap &&
                    cnt_q[3] <= Cap && cnt_q[4] <= Cap && cnt_q[5] <= Cap &&
                    cnt_q[6] <= Cap && cnt_q[7] <= Cap)
    else $error("cut count above saturation level");

  // no result is produced without a held previous column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_prev_q |=> !out_valid_q || $past(out_valid_q))
    else $error("result without previous column");

endmodule

[verif/isosurface_cube_row_classifier_tb.sv]
// self-checking testbench for the isosurface cube row classifier
`timescale 1ns / 100ps

module isosurface_cube_row_classifier_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES = 64;
  localparam int unsigned MAX_REPORTS = 100;
  localparam int unsigned LONG_ROW = 1031;

  typedef logic signed [icrc_pkg::SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [icrc_pkg::CASE_W-1:0] cube_case;
    icrc_pkg::cnt_vec_t          cuts;
    logic                        row_done;
  } cube_result_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  sample_t      cfg_wdata_i;
  logic         in_valid_i;
  logic         in_ready_o;
  sample_t      sample_a_i;
  sample_t      sample_b_i;
  sample_t      sample_c_i;
  sample_t      sample_d_i;
  logic         y_end_i;
  logic         z_end_i;
  logic         last_in_row_i;
  logic         out_valid_o;
  logic         out_ready_i;
  logic [icrc_pkg::CASE_W-1:0] cube_case_o;
  logic [icrc_pkg::CNT_W-1:0]  row_a_x_cuts_o;
  logic [icrc_pkg::CNT_W-1:0]  row_a_y_cuts_o;
  logic [icrc_pkg::CNT_W-1:0]  row_a_z_cuts_o;
  logic [icrc_pkg::CNT_W-1:0]  row_b_x_cuts_o;
  logic [icrc_pkg::CNT_W-1:0]  row_b_z_cuts_o;
  logic [icrc_pkg::CNT_W-1:0]  row_c_x_cuts_o;
  logic [icrc_pkg::CNT_W-1:0]  row_c_y_cuts_o;
  logic [icrc_pkg::CNT_W-1:0]  row_d_x_cuts_o;
  logic                        row_done_o;

  // classifier model state
  sample_t            iso_model = '0;
  logic [3:0]         held_inside = '0;
  bit                 row_open = 1'b0;
  icrc_pkg::cnt_vec_t cut_tally = '0;

  cube_result_t pending_cubes[$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  burst_left = 0;
  bit           hold_pending = 1'b0;

  string cut_names [icrc_pkg::NUM_COUNTS] = '{"row_a_x_cuts", "row_a_y_cuts",
                                              "row_a_z_cuts", "row_b_x_cuts",
                                              "row_b_z_cuts", "row_c_x_cuts",
                                              "row_c_y_cuts", "row_d_x_cuts"};

  isosurface_cube_row_classifier dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_a_i     (sample_a_i),
    .sample_b_i     (sample_b_i),
    .sample_c_i     (sample_c_i),
    .sample_d_i     (sample_d_i),
    .y_end_i        (y_end_i),
    .z_end_i        (z_end_i),
    .last_in_row_i  (last_in_row_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cube_case_o    (cube_case_o),
    .row_a_x_cuts_o (row_a_x_cuts_o),
    .row_a_y_cuts_o (row_a_y_cuts_o),
    .row_a_z_cuts_o (row_a_z_cuts_o),
    .row_b_x_cuts_o (row_b_x_cuts_o),
    .row_b_z_cuts_o (row_b_z_cuts_o),
    .row_c_x_cuts_o (row_c_x_cuts_o),
    .row_c_y_cuts_o (row_c_y_cuts_o),
    .row_d_x_cuts_o (row_d_x_cuts_o),
    .row_done_o     (row_done_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // cycle counter with run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("isosurface_cube_row_classifier: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    // keep the log short when the block is badly broken
    if (error_count < MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic logic [icrc_pkg::CNT_W-1:0] sat_add(
      input logic [icrc_pkg::CNT_W-1:0] val, input int unsigned inc);
    int unsigned sum;
    sum = val + inc;
    return (sum > icrc_pkg::CNT_CAP) ? icrc_pkg::CNT_CAP[icrc_pkg::CNT_W-1:0]
                                     : sum[icrc_pkg::CNT_W-1:0];
  endfunction

  function automatic int unsigned crossing(input logic [7:0] cube, input int p, input int q);
    return int'(cube[p] ^ cube[q]);
  endfunction

  function automatic void clear_row_state();
    row_open = 1'b0;
    held_inside = '0;
    cut_tally = '0;
  endfunction

  // model of one accepted column: inside marking, cube case and cut counts
  function automatic void classify_column(input sample_t sa, sb, sc, sd,
                                          input logic ye, ze, xe);
    logic [3:0]   cur;
    logic [7:0]   cube;
    cube_result_t res;
    cur = {sd >= iso_model, sc >= iso_model, sb >= iso_model, sa >= iso_model};
    // first column of a row closes no cube
    if (!row_open) begin
      if (xe) begin
        clear_row_state();
      end else begin
        held_inside = cur;
        row_open = 1'b1;
      end
      return;
    end
    // v7 .. v0
    cube = {held_inside[3], cur[3], cur[2], held_inside[2],
            held_inside[1], cur[1], cur[0], held_inside[0]};
    cut_tally[icrc_pkg::CNT_A_X] = sat_add(cut_tally[icrc_pkg::CNT_A_X], crossing(cube, 0, 1));
    cut_tally[icrc_pkg::CNT_A_Y] = sat_add(cut_tally[icrc_pkg::CNT_A_Y],
        crossing(cube, 0, 3) + (xe ? crossing(cube, 1, 2) : 0));
    cut_tally[icrc_pkg::CNT_A_Z] = sat_add(cut_tally[icrc_pkg::CNT_A_Z],
        crossing(cube, 0, 4) + (xe ? crossing(cube, 1, 5) : 0));
    if (ye) begin
      cut_tally[icrc_pkg::CNT_B_X] = sat_add(cut_tally[icrc_pkg::CNT_B_X],
          crossing(cube, 2, 3));
      cut_tally[icrc_pkg::CNT_B_Z] = sat_add(cut_tally[icrc_pkg::CNT_B_Z],
          crossing(cube, 3, 7) + (xe ? crossing(cube, 2, 6) : 0));
    end
    if (ze) begin
      cut_tally[icrc_pkg::CNT_C_X] = sat_add(cut_tally[icrc_pkg::CNT_C_X],
          crossing(cube, 4, 5));
      cut_tally[icrc_pkg::CNT_C_Y] = sat_add(cut_tally[icrc_pkg::CNT_C_Y],
          crossing(cube, 4, 7) + (xe ? crossing(cube, 5, 6) : 0));
    end
    if (ye && ze) begin
      cut_tally[icrc_pkg::CNT_D_X] = sat_add(cut_tally[icrc_pkg::CNT_D_X],
          crossing(cube, 6, 7));
    end
    res.cube_case = cube;
    res.cuts = cut_tally;
    res.row_done = xe;
    pending_cubes.push_back(res);
    if (xe) begin
      clear_row_state();
    end else begin
      held_inside = cur;
    end
  endfunction

  // mix of full range, extremes and values around the level
  function automatic sample_t random_sample();
    int v;
    case ($urandom_range(0, 3))
      0: return sample_t'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: begin
        v = int'(iso_model) + int'($urandom_range(0, 8)) - 4;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return sample_t'(v);
      end
    endcase
  endfunction

  // one input transaction, predicted on acceptance
  task automatic send_column(input sample_t sa, sb, sc, sd, input logic ye, ze, xe);
    in_valid_i <= 1'b1;
    sample_a_i <= sa;
    sample_b_i <= sb;
    sample_c_i <= sc;
    sample_d_i <= sd;
    y_end_i <= ye;
    z_end_i <= ze;
    last_in_row_i <= xe;
    do @(posedge clk_i); while (!in_ready_o);
    classify_column(sa, sb, sc, sd, ye, ze, xe);
  endtask

  // bursts of random length separated by random gaps
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  // sender pauses until every expected result is back, then lets the pipe settle
  task automatic wait_for_results();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (pending_cubes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_cubes.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_cubes.size()));
      pending_cubes.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_iso_level(input sample_t level);
    wait_for_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= level;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    iso_model = level;
  endtask

  // level 0 after reset: single point row, extremes, flag mixes, short row
  task automatic test_directed_rows();
    send_column(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 1'b0, 1'b1);
    pace_sender();
    send_column(16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 1'b0, 1'b0, 1'b0);
    pace_sender();
    send_column(16'sh7fff, 16'sh8000, 16'shffff, 16'sh0000, 1'b1, 1'b0, 1'b0);
    pace_sender();
    send_column(16'sh0000, 16'shffff, 16'sh0000, 16'shffff, 1'b0, 1'b1, 1'b0);
    pace_sender();
    send_column(16'shffff, 16'sh0000, 16'shffff, 16'sh0000, 1'b1, 1'b1, 1'b0);
    pace_sender();
    send_column(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b1, 1'b1, 1'b1);
    pace_sender();
    send_column(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 1'b1, 1'b0);
    pace_sender();
    send_column(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1, 1'b1, 1'b1);
    wait_for_results();
  endtask

  // lowest and highest level, then samples right at and just below the level
  task automatic test_level_extremes();
    write_iso_level(16'sh8000);
    send_column(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh0000, 1'b0, 1'b0, 1'b0);
    send_column(16'sh7fff, 16'sh8000, 16'sh0000, 16'sh8000, 1'b1, 1'b1, 1'b1);
    write_iso_level(16'sh7fff);
    send_column(16'sh7fff, 16'sh7ffe, 16'sh8000, 16'sh7fff, 1'b1, 1'b0, 1'b0);
    pace_sender();
    send_column(16'sh7ffe, 16'sh7fff, 16'sh7fff, 16'shffff, 1'b0, 1'b1, 1'b0);
    pace_sender();
    send_column(16'sh7fff, 16'sh7fff, 16'sh7ffe, 16'sh7ffe, 1'b1, 1'b1, 1'b1);
    write_iso_level(16'sd5);
    send_column(16'sd5, 16'sd4, -16'sd5, 16'sd6, 1'b1, 1'b1, 1'b0);
    send_column(16'sd4, 16'sd5, 16'sd6, 16'sh8000, 1'b1, 1'b1, 1'b1);
    wait_for_results();
  endtask

  // a full-length row where every edge is cut, so all counts saturate
  task automatic test_count_saturation();
    sample_t hi;
    sample_t lo;
    write_iso_level(16'sh0000);
    for (int unsigned i = 0; i < LONG_ROW; i++) begin
      hi = {1'b0, 15'($urandom)};
      lo = {1'b1, 15'($urandom)};
      if (i[0]) send_column(hi, lo, lo, hi, 1'b1, 1'b1, i == LONG_ROW - 1);
      else      send_column(lo, hi, hi, lo, 1'b1, 1'b1, i == LONG_ROW - 1);
      pace_sender();
    end
    wait_for_results();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_input_stall();
    wait_for_results();
    hold_pending = 1'b1;
    for (int unsigned i = 0; i < 40; i++) begin
      send_column(random_sample(), random_sample(), random_sample(), random_sample(),
                  1'b1, 1'b1, i == 39);
    end
    wait_for_results();
  endtask

  // random rows, mostly short, some single point, a few longer
  task automatic test_random_rows(input int unsigned n_items);
    int unsigned sent;
    int unsigned row_len;
    logic ye;
    logic ze;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 15))
        0: row_len = 1;
        1: row_len = $urandom_range(20, 60);
        default: row_len = $urandom_range(2, 12);
      endcase
      ye = $urandom_range(0, 1);
      ze = $urandom_range(0, 1);
      for (int unsigned i = 0; i < row_len; i++) begin
        // flags may also change inside a row
        if ($urandom_range(0, 7) == 0) begin
          ye = $urandom_range(0, 1);
          ze = $urandom_range(0, 1);
        end
        send_column(random_sample(), random_sample(), random_sample(), random_sample(),
                    ye, ze, i == row_len - 1);
        pace_sender();
      end
      sent += row_len;
    end
  endtask

  // random phases, each under its own level
  task automatic test_random_levels();
    sample_t level;
    for (int unsigned phase = 0; phase < 6; phase++) begin
      case (phase)
        1: level = 16'sh8000;
        2: level = 16'sh7fff;
        3: level = 16'sh0000;
        default: level = sample_t'($urandom);
      endcase
      write_iso_level(level);
      test_random_rows(30);
    end
    wait_for_results();
  endtask

  // result side: stall patterns in segments, plus the requested long hold
  initial begin : result_receiver
    rx_mode_e    mode;
    int unsigned seg_left;
    logic [7:0]  pattern;
    mode = RX_ALWAYS;
    seg_left = 0;
    pattern = 8'hff;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (seg_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 2));
          seg_left = $urandom_range(16, 160);
          pattern = 8'($urandom) | 8'h01;
        end else begin
          seg_left--;
        end
        case (mode)
          RX_ALWAYS: out_ready_i <= 1'b1;
          RX_RANDOM: out_ready_i <= ($urandom_range(0, 3) != 0);
          default: begin
            out_ready_i <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
          end
        endcase
      end
    end
  end

  // compare every result transaction with the oldest prediction
  always @(posedge clk_i) begin : check_results
    cube_result_t       want;
    icrc_pkg::cnt_vec_t seen_cuts;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_cubes.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = pending_cubes.pop_front();
        seen_cuts[icrc_pkg::CNT_A_X] = row_a_x_cuts_o;
        seen_cuts[icrc_pkg::CNT_A_Y] = row_a_y_cuts_o;
        seen_cuts[icrc_pkg::CNT_A_Z] = row_a_z_cuts_o;
        seen_cuts[icrc_pkg::CNT_B_X] = row_b_x_cuts_o;
        seen_cuts[icrc_pkg::CNT_B_Z] = row_b_z_cuts_o;
        seen_cuts[icrc_pkg::CNT_C_X] = row_c_x_cuts_o;
        seen_cuts[icrc_pkg::CNT_C_Y] = row_c_y_cuts_o;
        seen_cuts[icrc_pkg::CNT_D_X] = row_d_x_cuts_o;
        if (cube_case_o !== want.cube_case)
          report_mismatch($sformatf("cube_case got %02h expected %02h",
                                    cube_case_o, want.cube_case));
        for (int n = 0; n < icrc_pkg::NUM_COUNTS; n++) begin
          if (seen_cuts[n] !== want.cuts[n])
            report_mismatch($sformatf("%s got %0d expected %0d",
                                      cut_names[n], seen_cuts[n], want.cuts[n]));
        end
        if (row_done_o !== want.row_done)
          report_mismatch($sformatf("row_done got %b expected %b",
                                    row_done_o, want.row_done));
      end
    end
  end

  // test sequence
  initial begin : run_tests
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    sample_a_i <= '0;
    sample_b_i <= '0;
    sample_c_i <= '0;
    sample_d_i <= '0;
    y_end_i <= 1'b0;
    z_end_i <= 1'b0;
    last_in_row_i <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_rows();
    test_level_extremes();
    test_count_saturation();
    test_input_stall();
    test_random_levels();

    wait_for_results();
    if (error_count == 0) begin
      $display("isosurface_cube_row_classifier: match");
    end else begin
      $display("isosurface_cube_row_classifier: mismatch");
    end
    $finish;
  end

endmodule
